// File: design/linear_adsr_envelope_defines.svh
// ----------------------------------------------------------------------------
// linear_adsr_envelope_defines
// Assertion macros shared by the envelope modules. Each expects clk and
// arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ADSR_ENVELOPE_DEFINES_SVH
`define LINEAR_ADSR_ENVELOPE_DEFINES_SVH

// cond must hold at every clock edge outside reset
`define LAE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define LAE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define LAE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/lae_pkg.sv
// ----------------------------------------------------------------------------
// lae_pkg
// Types, constants and helpers of the linear ADSR envelope.
// ----------------------------------------------------------------------------
package lae_pkg;

	localparam int unsigned STEP_W     = 26;  // Q2.24 step
	localparam int unsigned PHASE_W    = 25;  // phase never exceeds 1.0
	localparam int unsigned LEVEL_W    = 17;  // Q1.16, unity included
	localparam int unsigned SAMPLE_W   = 24;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned FRAC_W     = 24;
	localparam int unsigned LANE_PROD_W = SAMPLE_W + LEVEL_W + 1;

	localparam logic [LEVEL_W-1:0] UNITY   = LEVEL_W'(65536);
	localparam logic [STEP_W:0]    ONE_Q24 = (STEP_W + 1)'(16777216);

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK     = 2'd0,
		MODE_NOTE_ON  = 2'd1,
		MODE_NOTE_OFF = 2'd2,
		MODE_RESET    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OFF     = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} stage_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_ATTACK_STEP   = 3'd0,
		CFG_DECAY_STEP    = 3'd1,
		CFG_RELEASE_STEP  = 3'd2,
		CFG_SUSTAIN_LEVEL = 3'd3,
		CFG_ATTACK_EN     = 3'd4,
		CFG_DECAY_EN      = 3'd5
	} cfg_index_t;

	typedef enum logic [1:0] {
		GAIN_ZERO    = 2'd0,
		GAIN_SUSTAIN = 2'd1,
		GAIN_INTERP  = 2'd2
	} gain_kind_t;

	typedef struct packed {
		logic [STEP_W-1:0]  attack_step;
		logic [STEP_W-1:0]  decay_step;
		logic [STEP_W-1:0]  release_step;
		logic [LEVEL_W-1:0] sustain_level;
		logic               attack_enable;
		logic               decay_enable;
	} cfg_t;

	typedef struct packed {
		logic               busy;        // a tick is inside the gain pipeline
		logic               gain_valid;  // gain holds the level of that tick
		logic [LEVEL_W-1:0] gain;
	} env_status_t;

	function automatic logic [LEVEL_W-1:0] sustain_sat(input logic [LEVEL_W-1:0] lvl);
		return (lvl > UNITY) ? UNITY : lvl;
	endfunction

endpackage

// File: design/lae_lane.sv
// ----------------------------------------------------------------------------
// lae_lane
// One channel lane: registered sample times level, floor shift by 16.
// ----------------------------------------------------------------------------
module lae_lane
	import lae_pkg::*;
(
	input  logic                clk,
	input  logic                load,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [LEVEL_W-1:0]  gain,
	output logic [SAMPLE_W-1:0] scaled
);

	logic signed [LANE_PROD_W-1:0] prod_s4;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s4 <= LANE_PROD_W'($signed(sample) * $signed({1'b0, gain}));
		end
	end

	// arithmetic shift right by 16 is a plain slice of the signed product
	assign scaled = prod_s4[SAMPLE_W+15:16];

endmodule

// File: design/lae_env_core.sv
// ----------------------------------------------------------------------------
// lae_env_core
// Envelope state machine and the interpolation pipeline that yields one
// level per sample tick.
// ----------------------------------------------------------------------------
`include "linear_adsr_envelope_defines.svh"

module lae_env_core
	import lae_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        req,
	input  mode_t       mode,
	output env_status_t status
);

	stage_t             stage_q, stage_d;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [LEVEL_W-1:0] start_q, start_d;
	logic [LEVEL_W-1:0] last_q, last_d;

	logic v_s1, v_s2, v_s3;

	// operand and result stages (payload)
	logic [LEVEL_W-1:0] prod_s2;
	logic [LEVEL_W-1:0] start_s2;
	logic [LEVEL_W-1:0] sat_s2;
	logic               up_s2;
	gain_kind_t         kind_s2;
	logic [LEVEL_W-1:0] gain_s3;

	logic [LEVEL_W-1:0] sat;
	logic [LEVEL_W-1:0] gain_d;

	assign sat = sustain_sat(cfg.sustain_level);

	// next state
	always_comb begin
		logic [STEP_W-1:0] step;
		logic [STEP_W:0]   sum;
		logic              enter;
		stage_t            nxt;
		stage_d = stage_q;
		phase_d = phase_q;
		start_d = start_q;
		last_d  = last_q;
		step    = '0;
		sum     = '0;
		enter   = 1'b0;
		nxt     = ST_OFF;
		if (v_s2 && kind_s2 == GAIN_INTERP) begin
			last_d = gain_d;
		end
		if (req) begin
			case (mode)
				MODE_NOTE_ON: begin
					enter = 1'b1;
					if (cfg.attack_enable) begin
						nxt = ST_ATTACK;
					end else if (cfg.decay_enable) begin
						nxt = ST_DECAY;
					end else begin
						nxt = ST_SUSTAIN;
					end
				end
				MODE_NOTE_OFF: begin
					stage_d = ST_RELEASE;
					phase_d = '0;
					start_d = last_q;
				end
				MODE_RESET: begin
					enter = 1'b1;
					nxt   = ST_OFF;
				end
				MODE_TICK: begin
					case (stage_q)
						ST_ATTACK, ST_DECAY, ST_RELEASE: begin
							case (stage_q)
								ST_ATTACK: begin
									step = cfg.attack_step;
									nxt  = ST_DECAY;
								end
								ST_DECAY: begin
									step = cfg.decay_step;
									nxt  = ST_SUSTAIN;
								end
								default: begin
									step = cfg.release_step;
									nxt  = ST_OFF;
								end
							endcase
							sum = {2'b00, phase_q} + {1'b0, step};
							if (sum > ONE_Q24) begin
								enter = 1'b1;
							end else begin
								phase_d = sum[PHASE_W-1:0];
							end
						end
						ST_SUSTAIN: begin
						end
						default: begin
							stage_d = ST_OFF;
						end
					endcase
				end
				default: begin
				end
			endcase
		end
		if (enter) begin
			stage_d = nxt;
			phase_d = '0;
			case (nxt)
				ST_ATTACK: begin
					start_d = '0;
					last_d  = '0;
				end
				ST_DECAY: begin
					start_d = UNITY;
					last_d  = UNITY;
				end
				ST_SUSTAIN: begin
					start_d = sat;
					last_d  = sat;
				end
				default: begin
					stage_d = ST_OFF;
					start_d = '0;
					last_d  = '0;
				end
			endcase
		end
	end

	// interpolation operands from the updated state
	logic [LEVEL_W-1:0]   target;
	logic [LEVEL_W-1:0]   diff;
	logic                 up;
	gain_kind_t           kind;
	logic [2*LEVEL_W+PHASE_W-LEVEL_W-1:0] mul;

	always_comb begin
		case (stage_q)
			ST_ATTACK: begin
				target = UNITY;
				kind   = GAIN_INTERP;
			end
			ST_DECAY: begin
				target = sat;
				kind   = GAIN_INTERP;
			end
			ST_RELEASE: begin
				target = '0;
				kind   = GAIN_INTERP;
			end
			ST_SUSTAIN: begin
				target = '0;
				kind   = GAIN_SUSTAIN;
			end
			default: begin
				target = '0;
				kind   = GAIN_ZERO;
			end
		endcase
		up   = (target >= start_q);
		diff = up ? (target - start_q) : (start_q - target);
	end

	assign mul = {{LEVEL_W{1'b0}}, phase_q} * {{PHASE_W{1'b0}}, diff};

	always_comb begin
		case (kind_s2)
			GAIN_INTERP:  gain_d = up_s2 ? (start_s2 + prod_s2) : (start_s2 - prod_s2);
			GAIN_SUSTAIN: gain_d = sat_s2;
			default:      gain_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_OFF;
			phase_q <= '0;
			start_q <= '0;
			last_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			stage_q <= stage_d;
			phase_q <= phase_d;
			start_q <= start_d;
			last_q  <= last_d;
			v_s1    <= req && (mode == MODE_TICK);
			v_s2    <= v_s1;
			v_s3    <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2  <= mul[FRAC_W+LEVEL_W-1:FRAC_W];
			start_s2 <= start_q;
			sat_s2   <= sat;
			up_s2    <= up;
			kind_s2  <= kind;
		end
		if (v_s2) begin
			gain_s3 <= gain_d;
		end
	end

	assign status.busy       = v_s1 | v_s2 | v_s3;
	assign status.gain_valid = v_s3;
	assign status.gain       = gain_s3;

	`LAE_ASSERT_ALWAYS(a_phase_le_one, {2'b00, phase_q} <= ONE_Q24, "phase above 1.0")
	`LAE_ASSERT_IMP(a_off_is_quiet, stage_q == ST_OFF, phase_q == '0 && start_q == '0 && last_q == '0, "off stage holds nonzero state")
	`LAE_ASSERT_ALWAYS(a_one_in_flight, $onehot0({v_s1, v_s2, v_s3}), "more than one tick in flight")

endmodule

// File: design/linear_adsr_envelope.sv
// ----------------------------------------------------------------------------
// linear_adsr_envelope
// Linear ADSR envelope applied to a multichannel sample frame, one lane of
// multiply per channel behind a shared envelope core.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Request moves                     Handshake
// s_axis    in   tuser: mode; tdata: samples       tvalid / tready
// m_axis    out  tdata: scaled samples, level      tvalid / tready
// cfg       in   register index and value          cfg_we, no wait
//
// A sample tick passes from acceptance to result through the envelope state
// update, interpolation multiply, level add, then the per-channel multiply.
// Note-on, note-off and reset requests finish in the cycle they are taken.
// tready drops while a tick is in flight or its result has not reached the
// output register; a full output register stalls only the last stage.
// Reset puts the envelope in its off stage; registers take their defaults.
//
`include "linear_adsr_envelope_defines.svh"

module linear_adsr_envelope
	import lae_pkg::*;
#(
	parameter int unsigned CHANNELS = 2,
	localparam int unsigned IN_DATA_W  = ((SAMPLE_W * CHANNELS + 7) / 8) * 8,
	localparam int unsigned OUT_DATA_W = ((SAMPLE_W * CHANNELS + LEVEL_W + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input stream
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [IN_DATA_W-1:0]     s_axis_tdata,   // sample_0, sample_1, ...
	input  logic [MODE_W-1:0]        s_axis_tuser,   // mode
	// output stream
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [OUT_DATA_W-1:0]    m_axis_tdata,   // out_0, out_1, ..., level
	// configuration writes
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [STEP_W-1:0]        cfg_wdata
);

	// --- configuration registers ---
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_step   <= '0;
			cfg_q.decay_step    <= '0;
			cfg_q.release_step  <= '0;
			cfg_q.sustain_level <= UNITY;
			cfg_q.attack_enable <= 1'b1;
			cfg_q.decay_enable  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_addr))
				CFG_ATTACK_STEP:   cfg_q.attack_step   <= cfg_wdata;
				CFG_DECAY_STEP:    cfg_q.decay_step    <= cfg_wdata;
				CFG_RELEASE_STEP:  cfg_q.release_step  <= cfg_wdata;
				CFG_SUSTAIN_LEVEL: cfg_q.sustain_level <= cfg_wdata[LEVEL_W-1:0];
				CFG_ATTACK_EN:     cfg_q.attack_enable <= cfg_wdata[0];
				CFG_DECAY_EN:      cfg_q.decay_enable  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// --- input acceptance ---
	env_status_t st;
	logic        in_fire;
	logic        v_s4;
	mode_t       in_mode;

	assign s_axis_tready = !(st.busy || v_s4);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign in_mode       = mode_t'(s_axis_tuser);

	// samples wait here while the level is worked out
	logic [SAMPLE_W-1:0] sample_q [CHANNELS];

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				sample_q[ch] <= s_axis_tdata[ch*SAMPLE_W +: SAMPLE_W];
			end
		end
	end

	// --- envelope core ---
	lae_env_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (in_fire),
		.mode   (in_mode),
		.status (st)
	);

	// --- channel lanes ---
	logic [SAMPLE_W-1:0] lane_res [CHANNELS];

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
		lae_lane u_lane (
			.clk    (clk),
			.load   (st.gain_valid),
			.sample (sample_q[ch]),
			.gain   (st.gain),
			.scaled (lane_res[ch])
		);
	end

	// --- merge into the output register ---
	logic [LEVEL_W-1:0]  level_s4;
	logic [SAMPLE_W-1:0] out_q [CHANNELS];
	logic [LEVEL_W-1:0]  level_q;
	logic                out_valid_q;
	logic                out_load;

	// lanes hold their product until the output register has room
	assign out_load = v_s4 && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (st.gain_valid) begin
				v_s4 <= 1'b1;
			end else if (out_load) begin
				v_s4 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st.gain_valid) begin
			level_s4 <= st.gain;
		end
		if (out_load) begin
			level_q <= level_s4;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				out_q[ch] <= lane_res[ch];
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		m_axis_tdata = '0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			m_axis_tdata[ch*SAMPLE_W +: SAMPLE_W] = out_q[ch];
		end
		m_axis_tdata[CHANNELS*SAMPLE_W +: LEVEL_W] = level_q;
	end

	// --- checks ---
	`LAE_ASSERT_NEXT(a_tick_blocks_input, in_fire && in_mode == MODE_TICK, !s_axis_tready, "input taken during a tick")
	`LAE_ASSERT_IMP(a_level_range, out_valid_q, level_q <= UNITY, "level above unity")
	`LAE_ASSERT_ALWAYS(a_single_result, !(st.gain_valid && v_s4), "two results in the lanes")

endmodule

// File: tb/sv/tb_linear_adsr_envelope.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_adsr_envelope
// Self-checking bench for the linear ADSR envelope. A scoreboard class tracks
// the stage, phase and levels of the envelope, predicts every tick's scaled
// frame and compares each output request field by field. Directed requests
// cover the stage corners first. Random note sequences under changing
// register settings and random backpressure follow.
// ----------------------------------------------------------------------------
module tb_linear_adsr_envelope;
	import lae_pkg::*;

	localparam int IN_W        = 48;    // sample_0, sample_1
	localparam int OUT_W       = 72;    // out_0, out_1, level, zero pad
	localparam int HOLD_LEN    = 400;   // receiver hold-off, in cycles
	localparam int WATCH_LIMIT = 5000;  // cycles with no request moving
	localparam int SETTLE_LEN  = 10;    // idle cycles once the expected frames drain

	// ------------------------------------------------------------------
	// Scoreboard: own copy of the envelope state and registers
	// ------------------------------------------------------------------
	class adsr_scoreboard;
		typedef struct {
			logic [SAMPLE_W-1:0] left;
			logic [SAMPLE_W-1:0] right;
			logic [LEVEL_W-1:0]  lvl;
		} frame_t;

		logic [STEP_W-1:0]  atk_step, dec_step, rel_step;
		logic [LEVEL_W-1:0] sus_reg;
		logic               atk_en, dec_en;

		stage_t             stage;
		logic [STEP_W-1:0]  phase;
		logic [LEVEL_W-1:0] start_lvl, last_lvl;

		frame_t frames_due[$];
		int     errors;

		function new();
			atk_step  = '0;
			dec_step  = '0;
			rel_step  = '0;
			sus_reg   = UNITY;
			atk_en    = 1'b1;
			dec_en    = 1'b1;
			stage     = ST_OFF;
			phase     = '0;
			start_lvl = '0;
			last_lvl  = '0;
			errors    = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [STEP_W-1:0] v);
			case (idx)
				CFG_ATTACK_STEP:   atk_step = v;
				CFG_DECAY_STEP:    dec_step = v;
				CFG_RELEASE_STEP:  rel_step = v;
				CFG_SUSTAIN_LEVEL: sus_reg  = v[LEVEL_W-1:0];
				CFG_ATTACK_EN:     atk_en   = v[0];
				CFG_DECAY_EN:      dec_en   = v[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return frames_due.size();
		endfunction

		// sustain register saturates at unity
		function logic [LEVEL_W-1:0] capped_sustain();
			return (sus_reg > UNITY) ? UNITY : sus_reg;
		endfunction

		function void enter(stage_t s);
			stage = s;
			phase = '0;
			case (s)
				ST_ATTACK: begin
					start_lvl = '0;
					last_lvl  = '0;
				end
				ST_DECAY: begin
					start_lvl = UNITY;
					last_lvl  = UNITY;
				end
				ST_SUSTAIN: begin
					start_lvl = capped_sustain();
					last_lvl  = start_lvl;
				end
				ST_RELEASE: start_lvl = last_lvl;
				default: begin
					stage     = ST_OFF;
					start_lvl = '0;
					last_lvl  = '0;
				end
			endcase
		endfunction

		// start + phase*(target-start), product truncated toward start
		function logic [LEVEL_W-1:0] ramp_level();
			logic [LEVEL_W-1:0] tgt;
			longint unsigned    prod;
			case (stage)
				ST_ATTACK: tgt = UNITY;
				ST_DECAY:  tgt = capped_sustain();
				default:   tgt = '0;
			endcase
			if (tgt >= start_lvl) begin
				prod = longint'(phase) * longint'(tgt - start_lvl);
				return start_lvl + LEVEL_W'(prod >> FRAC_W);
			end
			prod = longint'(phase) * longint'(start_lvl - tgt);
			return start_lvl - LEVEL_W'(prod >> FRAC_W);
		endfunction

		// signed sample times level, floor of the shift by 16
		function logic [SAMPLE_W-1:0] scaled(logic [SAMPLE_W-1:0] s, logic [LEVEL_W-1:0] g);
			longint     prod;
			logic [63:0] q;
			prod = longint'($signed(s)) * longint'({1'b0, g});
			q    = prod >>> 16;
			return q[SAMPLE_W-1:0];
		endfunction

		function void note_input(logic [MODE_W-1:0] mode_bits, logic [IN_W-1:0] data);
			logic [STEP_W-1:0]  step;
			logic [STEP_W:0]    sum;
			logic [LEVEL_W-1:0] g;
			stage_t             nxt;
			frame_t             f;
			case (mode_t'(mode_bits))
				MODE_NOTE_ON: begin
					if (atk_en)
						enter(ST_ATTACK);
					else if (dec_en)
						enter(ST_DECAY);
					else
						enter(ST_SUSTAIN);
				end
				MODE_NOTE_OFF: enter(ST_RELEASE);
				MODE_RESET:    enter(ST_OFF);
				default: begin
					case (stage)
						ST_ATTACK, ST_DECAY, ST_RELEASE: begin
							if (stage == ST_ATTACK) begin
								step = atk_step;
								nxt  = ST_DECAY;
							end else if (stage == ST_DECAY) begin
								step = dec_step;
								nxt  = ST_SUSTAIN;
							end else begin
								step = rel_step;
								nxt  = ST_OFF;
							end
							// wide add: any step above 1.0 ends the stage now
							sum = {1'b0, phase} + {1'b0, step};
							if (sum > ONE_Q24)
								enter(nxt);
							else
								phase = sum[STEP_W-1:0];
							g        = ramp_level();
							last_lvl = g;
						end
						ST_SUSTAIN: g = capped_sustain();  // live register
						default: begin
							stage = ST_OFF;
							g     = '0;
						end
					endcase
					f.left  = scaled(data[SAMPLE_W-1:0], g);
					f.right = scaled(data[2*SAMPLE_W-1:SAMPLE_W], g);
					f.lvl   = g;
					frames_due.push_back(f);
				end
			endcase
		endfunction

		function void check_result(logic [OUT_W-1:0] d);
			frame_t             want;
			logic [SAMPLE_W-1:0] l, r;
			logic [LEVEL_W-1:0]  lv;
			l  = d[SAMPLE_W-1:0];
			r  = d[2*SAMPLE_W-1:SAMPLE_W];
			lv = d[2*SAMPLE_W+LEVEL_W-1:2*SAMPLE_W];
			if (frames_due.size() == 0) begin
				$display("%0t: output request with none expected: %h", $time, d);
				errors++;
				return;
			end
			want = frames_due.pop_front();
			if (l !== want.left) begin
				$display("%0t: out_0 expected %h actual %h", $time, want.left, l);
				errors++;
			end
			if (r !== want.right) begin
				$display("%0t: out_1 expected %h actual %h", $time, want.right, r);
				errors++;
			end
			if (lv !== want.lvl) begin
				$display("%0t: level expected %h actual %h", $time, want.lvl, lv);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT and its signals
	// ------------------------------------------------------------------
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata  = '0;  // sample_0, sample_1
	logic [MODE_W-1:0]     s_axis_tuser  = '0;  // mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;        // out_0, out_1, level
	logic                  cfg_we        = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
	logic [STEP_W-1:0]     cfg_wdata     = '0;

	linear_adsr_envelope #(
		.CHANNELS(2)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	always #6 clk = ~clk;

	adsr_scoreboard sb;
	int             items_sent = 0;
	int             quiet_cycles = 0;
	bit             tx_calm = 1'b0;   // sender offers back to back
	bit             rx_calm = 1'b0;   // receiver always ready
	int             hold_token = 0;   // bump to start a receiver hold-off

	// ------------------------------------------------------------------
	// Receiver: random tready, plus a long hold-off on request
	// ------------------------------------------------------------------
	initial begin : rx_side
		int hold_left;
		int seen;
		hold_left = 0;
		seen      = 0;
		forever begin
			@(posedge clk);
			if (hold_token != seen) begin
				seen      = hold_token;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_calm) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= 18);
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor and watchdog. Values read here are the ones before the edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input(s_axis_tuser, s_axis_tdata);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCH_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, WATCH_LIMIT);
				$display("linear_adsr_envelope regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 19))
			0:       return 24'h7FFFFF;
			1:       return 24'h800000;
			2:       return 24'h000000;
			3:       return 24'hFFFFFF;
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// mostly stage lengths of a few dozen ticks, with the corners mixed in
	function automatic logic [STEP_W-1:0] pick_step();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return 26'd33554432;
		if (r < 14)
			return STEP_W'(ONE_Q24);
		if (r < 17)
			return 26'd1;
		return STEP_W'(ONE_Q24 / $urandom_range(2, 48) + $urandom_range(0, 255));
	endfunction

	// one request; valid stays high into the next call unless a gap falls
	task automatic offer_frame(mode_t m, logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
		while (!tx_calm && $urandom_range(0, 99) < 18) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= m;
		s_axis_tdata  <= {r, l};
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic tick(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
		offer_frame(MODE_TICK, l, r);
	endtask

	// stop offering, drain expected frames, let the pipeline empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_LEN) @(posedge clk);
	endtask

	task automatic program_regs(logic [STEP_W-1:0] atk, logic [STEP_W-1:0] dec,
			logic [STEP_W-1:0] rel, logic [LEVEL_W-1:0] sus, logic aen, logic den);
		cfg_index_t        regs [6] = '{CFG_ATTACK_STEP, CFG_DECAY_STEP, CFG_RELEASE_STEP,
		                               CFG_SUSTAIN_LEVEL, CFG_ATTACK_EN, CFG_DECAY_EN};
		logic [STEP_W-1:0] vals [6];
		vals = '{atk, dec, rel, STEP_W'(sus), STEP_W'(aen), STEP_W'(den)};
		settle();
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= regs[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
			sb.set_reg(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// note sequences with random content, some noise between them
	task automatic run_sequences(int budget);
		int stop_at;
		int n;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 85) begin
				offer_frame(MODE_NOTE_ON, rand_sample(), rand_sample());
				n = $urandom_range(1, 40);
				repeat (n) tick(rand_sample(), rand_sample());
				offer_frame(MODE_NOTE_OFF, rand_sample(), rand_sample());
				n = $urandom_range(0, 30);
				repeat (n) tick(rand_sample(), rand_sample());
				if ($urandom_range(0, 3) == 0) begin
					offer_frame(MODE_RESET, rand_sample(), rand_sample());
					tick(rand_sample(), rand_sample());
				end
			end else begin
				n = $urandom_range(1, 5);
				repeat (n) offer_frame(mode_t'($urandom_range(0, 3)), rand_sample(), rand_sample());
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [LEVEL_W-1:0] sus;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: zero steps, so attack and release hold forever
		tick(24'h7FFFFF, 24'h800000);              // off stage gives zeros
		offer_frame(MODE_NOTE_ON, 24'h0, 24'h0);
		tick(24'h7FFFFF, 24'h800000);
		offer_frame(MODE_NOTE_OFF, 24'h0, 24'h0);
		tick(24'hFFFFFF, 24'h000001);
		offer_frame(MODE_RESET, 24'h0, 24'h0);
		tick(24'hFFFFFF, 24'h000001);

		// largest steps end a stage in one tick; a step of exactly 1.0 sits
		// on the target for one tick before moving on
		program_regs(26'd33554432, STEP_W'(ONE_Q24), 26'd33554432, UNITY, 1'b1, 1'b1);
		offer_frame(MODE_NOTE_ON, 24'h0, 24'h0);
		tick(24'h7FFFFF, 24'h800000);
		tick(24'h7FFFFF, 24'h800000);
		tick(24'h123456, 24'hEDCBA9);
		tick(24'h7FFFFF, 24'h800000);
		offer_frame(MODE_NOTE_OFF, 24'h0, 24'h0);
		tick(24'h7FFFFF, 24'h800000);
		tick(24'h7FFFFF, 24'h800000);

		// no attack: note-on enters decay, falling to a zero sustain
		program_regs(26'h0400000, 26'h0555555, 26'h0300000, '0, 1'b0, 1'b1);
		offer_frame(MODE_NOTE_ON, 24'h0, 24'h0);
		repeat (3) tick(24'h7FFFFF, 24'h800000);
		offer_frame(MODE_NOTE_OFF, 24'h0, 24'h0);
		repeat (2) tick(24'h800000, 24'h7FFFFF);

		// neither attack nor decay: straight to sustain; the sustain gain
		// follows the register while release starts from the entry level
		program_regs('0, '0, 26'h0200000, 17'd32768, 1'b0, 1'b0);
		offer_frame(MODE_NOTE_ON, 24'h0, 24'h0);
		tick(24'h800000, 24'h7FFFFF);
		program_regs('0, '0, 26'h0200000, UNITY, 1'b0, 1'b0);
		tick(24'h800000, 24'h7FFFFF);
		offer_frame(MODE_NOTE_OFF, 24'h0, 24'h0);
		repeat (2) tick(24'h7FFFFF, 24'h800000);

		// random register settings, one phase without any idling
		for (int ph = 0; ph < 20; ph++) begin
			case ($urandom_range(0, 3))
				0:       sus = '0;
				1:       sus = UNITY;
				default: sus = LEVEL_W'($urandom_range(0, 65536));
			endcase
			program_regs(pick_step(), pick_step(), pick_step(), sus,
				$urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
			if (ph == 7) begin
				tx_calm = 1'b1;
				rx_calm = 1'b1;
			end
			run_sequences(66);
			tx_calm = 1'b0;
			rx_calm = 1'b0;
		end

		// backpressure: receiver holds off while the sender keeps offering
		program_regs(26'h0100000, 26'h0080000, 26'h0200000, 17'd40000, 1'b1, 1'b1);
		tx_calm = 1'b1;
		hold_token++;
		run_sequences(60);
		tx_calm = 1'b0;

		settle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("linear_adsr_envelope regression: pass");
		end else begin
			$display("linear_adsr_envelope regression: fail");
		end
		$finish;
	end

endmodule
